// ===== rtl/slip_ratio_pid_torque_limiter_unit_assert.svh =====
// Assertion macros used by the checker of the traction control block.
`ifndef SLIP_RATIO_PID_TORQUE_LIMITER_UNIT_ASSERT_SVH
`define SLIP_RATIO_PID_TORQUE_LIMITER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define SRPTL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("traction control check failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define SRPTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("traction control check failed");

`endif

// ===== rtl/srptl_pkg.sv =====
package srptl_pkg;

    // Widths of the main datapath words.
    localparam int SPEED_W = 16;
    localparam int SUM_W   = SPEED_W + 1;
    localparam int QUO_W   = 15;
    localparam int CNT_W   = $clog2(QUO_W + 1);
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Upper clamp of the integral term.
    localparam logic [15:0] TORQUE_CEILING = 16'd65535;

    // Configuration register indexes.
    localparam logic [2:0] CFG_METHOD   = 3'd0;
    localparam logic [2:0] CFG_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_SLIP_LO  = 3'd2;
    localparam logic [2:0] CFG_SLIP_HI  = 3'd3;
    localparam logic [2:0] CFG_GAIN_P   = 3'd4;
    localparam logic [2:0] CFG_GAIN_I   = 3'd5;
    localparam logic [2:0] CFG_GAIN_D   = 3'd6;
    localparam logic [2:0] CFG_FLOOR    = 3'd7;

    // Reset values of the configuration registers.
    localparam logic        RST_METHOD  = 1'b0;
    localparam logic [15:0] RST_PERIOD  = 16'd10;
    localparam logic [15:0] RST_SLIP_LO = 16'd1638;
    localparam logic [15:0] RST_SLIP_HI = 16'd4915;
    localparam logic [15:0] RST_GAIN_P  = 16'd1000;
    localparam logic [15:0] RST_GAIN_I  = 16'hFFF6;
    localparam logic [15:0] RST_GAIN_D  = 16'd100;
    localparam logic [15:0] RST_FLOOR   = 16'd0;

    // Handshake between the sequencer and the serial divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/slip_ratio_pid_torque_limiter_unit.sv =====
// Traction control torque limiter. Each input transfer carries a time stamp,
// the pedal torque and four wheel speeds, and yields one result transfer.
// When the sample period has not elapsed the pedal torque is passed through.
// Otherwise the slip ratio is formed by a 15-step serial divider and, when
// the slip is neither inside nor below the window, a PID term is evaluated
// on one shared multiplier used three times; items whose slip saturates or
// whose rear speed is zero skip the divider. The block takes a new item only
// when the previous one has left the sequencer; a finished result may still
// wait in the output register.
module slip_ratio_pid_torque_limiter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_time_now,
    input  logic [15:0]        i_pedal_torque,
    input  logic [15:0]        i_speed_front_left,
    input  logic [15:0]        i_speed_front_right,
    input  logic [15:0]        i_speed_rear_left,
    input  logic [15:0]        i_speed_rear_right,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_torque_command,
    output logic               o_executed,
    output logic               o_limiting,
    output logic signed [15:0] o_slip_value,
    // Configuration port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_WIN  = 8'b0000_1000,
        S_MULP = 8'b0001_0000,
        S_MULI = 8'b0010_0000,
        S_MULD = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    localparam int SW = srptl_pkg::SUM_W;

    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic               r_method;
    logic [15:0]        r_period;
    logic signed [15:0] r_slip_lo;
    logic signed [15:0] r_slip_hi;
    logic signed [15:0] r_gain_p;
    logic signed [15:0] r_gain_i;
    logic signed [15:0] r_gain_d;
    logic [15:0]        r_floor;

    // Controller state
    logic [31:0]        r_last_time;
    logic [15:0]        r_integral;
    logic [15:0]        r_prior;

    // Captured input item
    logic [31:0]        r_now;
    logic [15:0]        r_pedal;
    logic [15:0]        r_fl;
    logic [15:0]        r_fr;
    logic [15:0]        r_rl;
    logic [15:0]        r_rr;

    // Working registers
    logic               r_neg;
    logic signed [15:0] r_slip;
    logic signed [17:0] r_p;
    logic [15:0]        r_cmd;
    logic               r_exec;
    logic               r_lim;

    // Output register
    logic               r_out_valid;
    logic [15:0]        r_o_cmd;
    logic               r_o_exec;
    logic               r_o_lim;
    logic signed [15:0] r_o_slip;

    logic                           w_accept;
    logic                           w_out_load;
    logic [SW-1:0]                  w_front;
    logic [SW-1:0]                  w_rear;
    logic signed [SW:0]             w_diff;
    logic [SW:0]                    w_abs;
    logic [SW-1:0]                  w_mag;
    logic [31:0]                    w_elapsed;
    logic                           w_run;
    logic signed [16:0]             w_tsum;
    logic signed [15:0]             w_target;
    logic signed [16:0]             w_err;
    logic signed [16:0]             w_pdiff;
    logic                           w_inside;
    logic                           w_below;
    logic signed [srptl_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [srptl_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [srptl_pkg::PROD_W-1:0]  w_prod;
    logic signed [17:0]             w_iterm;
    logic signed [18:0]             w_acc;
    logic [15:0]                    n_integral;
    logic signed [34:0]             w_sum;
    logic [15:0]                    n_cmd;
    srptl_pkg::t_div_req            w_div_req;
    srptl_pkg::t_div_rsp            w_div_rsp;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Front and rear speeds, the magnitude of their difference and the period test.
    always_comb begin
        if (r_method) begin
            w_front = {1'b0, (r_fl < r_fr) ? r_fl : r_fr};
            w_rear  = {1'b0, (r_rl > r_rr) ? r_rl : r_rr};
        end else begin
            w_front = {1'b0, r_fl} + {1'b0, r_fr};
            w_rear  = {1'b0, r_rl} + {1'b0, r_rr};
        end
        w_diff    = $signed({1'b0, w_rear}) - $signed({1'b0, w_front});
        w_abs     = w_diff[SW] ? (~w_diff + 1'b1) : w_diff;
        w_mag     = w_abs[SW-1:0];
        w_elapsed = r_now - r_last_time;
        w_run     = (w_elapsed >= {16'b0, r_period});
    end

    // Window test and error terms.
    always_comb begin
        w_tsum   = 17'(r_slip_lo) + 17'(r_slip_hi);
        w_target = w_tsum[16:1];
        w_err    = 17'(w_target) - 17'(r_slip);
        w_pdiff  = $signed({1'b0, r_pedal}) - $signed({1'b0, r_prior});
        w_inside = (r_slip > r_slip_lo) && (r_slip < r_slip_hi);
        w_below  = (r_slip < r_slip_lo);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_WIN: begin
                w_mul_a = r_gain_p;
                w_mul_b = w_err;
            end
            S_MULP: begin
                w_mul_a = r_gain_i;
                w_mul_b = w_err;
            end
            default: begin
                w_mul_a = r_gain_d;
                w_mul_b = w_pdiff;
            end
        endcase
    end

    srptl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_div_req.start    = (r_state == S_PREP) && w_run && (w_rear != '0) &&
                                (w_mag < w_rear);
    assign w_div_req.dividend = w_mag;
    assign w_div_req.divisor  = w_rear;

    srptl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Integral update with clamping to the floor and the ceiling.
    always_comb begin
        w_iterm = w_prod[srptl_pkg::PROD_W-1:15];
        w_acc   = $signed({3'b0, r_integral}) + 19'(w_iterm);
        if (w_acc < $signed({3'b0, r_floor})) begin
            n_integral = r_floor;
        end else if (w_acc > $signed({3'b0, srptl_pkg::TORQUE_CEILING})) begin
            n_integral = srptl_pkg::TORQUE_CEILING;
        end else begin
            n_integral = w_acc[15:0];
        end
    end

    // PID sum limited to the floor and the pedal; the pedal test wins.
    always_comb begin
        w_sum = 35'(r_p) + $signed({19'b0, r_integral}) + 35'(w_prod);
        if (w_sum > $signed({19'b0, r_pedal})) begin
            n_cmd = r_pedal;
        end else if (w_sum < $signed({19'b0, r_floor})) begin
            n_cmd = r_floor;
        end else begin
            n_cmd = w_sum[15:0];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                priority if (!w_run) begin
                    n_state = S_DONE;
                end else if (w_div_req.start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_WIN;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                n_state = (w_inside || w_below) ? S_DONE : S_MULP;
            end
            S_MULP: n_state = S_MULI;
            S_MULI: n_state = S_MULD;
            S_MULD: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_method    <= srptl_pkg::RST_METHOD;
            r_period    <= srptl_pkg::RST_PERIOD;
            r_slip_lo   <= srptl_pkg::RST_SLIP_LO;
            r_slip_hi   <= srptl_pkg::RST_SLIP_HI;
            r_gain_p    <= srptl_pkg::RST_GAIN_P;
            r_gain_i    <= srptl_pkg::RST_GAIN_I;
            r_gain_d    <= srptl_pkg::RST_GAIN_D;
            r_floor     <= srptl_pkg::RST_FLOOR;
            r_last_time <= '0;
            r_integral  <= '0;
            r_prior     <= '0;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    srptl_pkg::CFG_METHOD:  r_method  <= i_cfg_data[0];
                    srptl_pkg::CFG_PERIOD:  r_period  <= i_cfg_data;
                    srptl_pkg::CFG_SLIP_LO: r_slip_lo <= i_cfg_data;
                    srptl_pkg::CFG_SLIP_HI: r_slip_hi <= i_cfg_data;
                    srptl_pkg::CFG_GAIN_P:  r_gain_p  <= i_cfg_data;
                    srptl_pkg::CFG_GAIN_I:  r_gain_i  <= i_cfg_data;
                    srptl_pkg::CFG_GAIN_D:  r_gain_d  <= i_cfg_data;
                    srptl_pkg::CFG_FLOOR:   r_floor   <= i_cfg_data;
                    default: ;
                endcase
            end

            if ((r_state == S_PREP) && w_run) begin
                r_last_time <= r_now;
            end
            if ((r_state == S_WIN) && w_inside) begin
                r_integral <= '0;
                r_prior    <= '0;
            end
            if (r_state == S_MULI) begin
                r_integral <= n_integral;
            end
            if (r_state == S_MULD) begin
                r_prior <= r_pedal;
            end
        end
    end

    // Item capture and working values.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now   <= i_time_now;
            r_pedal <= i_pedal_torque;
            r_fl    <= i_speed_front_left;
            r_fr    <= i_speed_front_right;
            r_rl    <= i_speed_rear_left;
            r_rr    <= i_speed_rear_right;
        end

        if (r_state == S_PREP) begin
            r_cmd  <= r_pedal;
            r_lim  <= 1'b0;
            r_exec <= w_run;
            r_neg  <= w_diff[SW];
            priority if (!w_run || (w_rear == '0)) begin
                r_slip <= '0;
            end else if (w_mag >= w_rear) begin
                r_slip <= w_diff[SW] ? 16'sh8000 : 16'sh7FFF;
            end else begin
                r_slip <= '0;
            end
        end

        if ((r_state == S_DIV) && w_div_rsp.done) begin
            r_slip <= r_neg ? -$signed({1'b0, w_div_rsp.quotient})
                            : $signed({1'b0, w_div_rsp.quotient});
        end

        if (r_state == S_MULP) begin
            r_p <= w_prod[srptl_pkg::PROD_W-1:15];
        end

        if (r_state == S_MULD) begin
            r_cmd <= n_cmd;
            r_lim <= 1'b1;
        end

        if (w_out_load) begin
            r_o_cmd  <= r_cmd;
            r_o_exec <= r_exec;
            r_o_lim  <= r_lim;
            r_o_slip <= r_slip;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_torque_command = r_o_cmd;
    assign o_executed       = r_o_exec;
    assign o_limiting       = r_o_lim;
    assign o_slip_value     = r_o_slip;

endmodule

// ===== rtl/srptl_div.sv =====
// Restoring divider producing one quotient bit per cycle. The dividend is
// always below the divisor, so the quotient is a pure fraction of QUO_W bits.
module srptl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srptl_pkg::t_div_req i_req,
    output srptl_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [srptl_pkg::CNT_W-1:0]   r_cnt;
    logic [srptl_pkg::SUM_W-1:0]   r_rem;
    logic [srptl_pkg::SUM_W-1:0]   r_dvs;
    logic [srptl_pkg::QUO_W-1:0]   r_quo;
    logic [srptl_pkg::SUM_W:0]     w_shift;
    logic                          w_ge;
    logic [srptl_pkg::SUM_W:0]     w_sub;
    logic [srptl_pkg::SUM_W-1:0]   n_rem;

    // One compare-and-subtract step on the doubled remainder.
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_sub   = w_shift - {1'b0, r_dvs};
        n_rem   = w_ge ? w_sub[srptl_pkg::SUM_W-1:0] : w_shift[srptl_pkg::SUM_W-1:0];
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= srptl_pkg::CNT_W'(srptl_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == srptl_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[srptl_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/srptl_mul.sv =====
// Shared signed multiplier with a registered product, reused for the
// proportional, integral and derivative terms in turn.
module srptl_mul (
    input  logic                                i_clk,
    input  logic signed [srptl_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [srptl_pkg::MUL_B_W-1:0] i_b,
    output logic signed [srptl_pkg::PROD_W-1:0]  o_prod
);

    logic signed [srptl_pkg::PROD_W-1:0] r_prod;

    // Product is ready in the cycle after the operands are presented.
    always_ff @(posedge i_clk) begin
        r_prod <= srptl_pkg::PROD_W'(i_a) * srptl_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/srptl_checker.sv =====
`include "slip_ratio_pid_torque_limiter_unit_assert.svh"

// Port-level checks on the traction control block.
module srptl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [31:0]        i_time_now,
    input logic [15:0]        i_pedal_torque,
    input logic [15:0]        i_speed_front_left,
    input logic [15:0]        i_speed_front_right,
    input logic [15:0]        i_speed_rear_left,
    input logic [15:0]        i_speed_rear_right,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [15:0]        o_torque_command,
    input logic               o_executed,
    input logic               o_limiting,
    input logic signed [15:0] o_slip_value,
    input logic               i_cfg_we,
    input logic [2:0]         i_cfg_index,
    input logic [15:0]        i_cfg_data
);

    // The whole offered result, valid flag included.
    logic [34:0] w_out_word;

    assign w_out_word = {o_out_valid, o_torque_command, o_executed, o_limiting, o_slip_value};

    // A stalled result stays offered and unchanged.
    `SRPTL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, $stable(w_out_word))

    // A skipped control step reports neither limiting nor slip.
    `SRPTL_ASSERT_SAME(a_skip_clean, o_out_valid && !o_executed, !o_limiting && (o_slip_value == 16'sd0))

    // Limiting only happens when the controller actually ran.
    `SRPTL_ASSERT_SAME(a_lim_exec, o_out_valid && o_limiting, o_executed)

    // After an input transfer the block is busy with that item.
    `SRPTL_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind slip_ratio_pid_torque_limiter_unit srptl_checker u_srptl_checker (.*);
